// ----- hdl/sts_pkg.sv -----
// shared types, token codes and keyword table of the token scanner
package sts_pkg;

  localparam int KwPrefixLen = 6;

  localparam logic [5:0] K_LPAREN = 6'd0;
  localparam logic [5:0] K_RPAREN = 6'd1;
  localparam logic [5:0] K_LBRACE = 6'd2;
  localparam logic [5:0] K_RBRACE = 6'd3;
  localparam logic [5:0] K_COMMA  = 6'd4;
  localparam logic [5:0] K_DOT    = 6'd5;
  localparam logic [5:0] K_MINUS  = 6'd6;
  localparam logic [5:0] K_PLUS   = 6'd7;
  localparam logic [5:0] K_SEMI   = 6'd8;
  localparam logic [5:0] K_SLASH  = 6'd9;
  localparam logic [5:0] K_STAR   = 6'd10;
  localparam logic [5:0] K_IDENT  = 6'd19;
  localparam logic [5:0] K_STR    = 6'd20;
  localparam logic [5:0] K_NUM    = 6'd21;
  localparam logic [5:0] K_EOF    = 6'd38;
  localparam logic [5:0] K_ERR    = 6'd39;

  localparam logic [1:0] E_NONE  = 2'd0;
  localparam logic [1:0] E_UNEXP = 2'd1;
  localparam logic [1:0] E_UNTRM = 2'd2;

  localparam logic [7:0] C_NL    = 8'h0a;
  localparam logic [7:0] C_DOT   = 8'h2e;
  localparam logic [7:0] C_EQ    = 8'h3d;
  localparam logic [7:0] C_SLASH = 8'h2f;
  localparam logic [7:0] C_QUOTE = 8'h22;

  // one-char kinds for ! = < >, two-char form is kind + 1
  localparam logic [5:0] OP_KIND [4] = '{6'd11, 6'd13, 6'd17, 6'd15};

  typedef enum logic [3:0] {
    CC_ALPHA, CC_DIGIT, CC_BLANK, CC_NL, CC_PUNCT,
    CC_OPST, CC_SLASH, CC_QUOTE, CC_OTHER
  } cls_t;

  typedef enum logic [3:0] {
    M_IDLE, M_WORD, M_INT, M_NUMDOT, M_FRAC, M_OP, M_SLASH, M_STRING, M_COMMENT
  } mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    cls_t       cls;
    logic [5:0] pkind;
    logic [1:0] opi;
  } item_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [19:0] start;
    logic [19:0] len;
    logic [19:0] line;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic [2:0]  len;
    logic [47:0] text;
    logic [5:0]  kind;
  } kw_t;

  localparam kw_t KW_TABLE [16] = '{
    '{3'd3, {"and", 24'h0},    6'd22}, '{3'd5, {"class", 8'h0}, 6'd23},
    '{3'd4, {"else", 16'h0},   6'd24}, '{3'd5, {"false", 8'h0}, 6'd25},
    '{3'd3, {"for", 24'h0},    6'd26}, '{3'd3, {"fun", 24'h0},  6'd27},
    '{3'd2, {"if", 32'h0},     6'd28}, '{3'd3, {"nil", 24'h0},  6'd29},
    '{3'd2, {"or", 32'h0},     6'd30}, '{3'd5, {"print", 8'h0}, 6'd31},
    '{3'd6, "return",          6'd32}, '{3'd5, {"super", 8'h0}, 6'd33},
    '{3'd4, {"this", 16'h0},   6'd34}, '{3'd4, {"true", 16'h0}, 6'd35},
    '{3'd3, {"var", 24'h0},    6'd36}, '{3'd5, {"while", 8'h0}, 6'd37}
  };

  // prefix holds the first char in the top byte
  function automatic logic [5:0] kw_kind(logic [47:0] pfx, logic [2:0] n);
    logic [47:0] mask;
    logic [5:0]  k;
    mask = ~(48'hffff_ffff_ffff >> (6'd8 * 6'(n)));
    k = K_IDENT;
    for (int i = 15; i >= 0; i--) begin
      if (KW_TABLE[i].len == n && ((pfx ^ KW_TABLE[i].text) & mask) == 48'h0) begin
        k = KW_TABLE[i].kind;
      end
    end
    return k;
  endfunction

endpackage

// ----- hdl/sts_front.sv -----
// front end: classifies source bytes and queues them for the scanner
module sts_front import sts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       src_valid,
  output logic       src_stall,
  input  logic [7:0] source_byte,
  input  logic       end_of_source,
  output logic       item_valid,
  output item_t      item,
  input  logic       item_take
);

  item_t      ent [2];
  logic       wp, rp;
  logic [1:0] count;
  item_t      cls_item;
  logic       push;

  always_comb begin
    cls_item       = '0;
    cls_item.ch    = source_byte;
    cls_item.last  = end_of_source || source_byte == 8'h00;
    cls_item.cls   = CC_OTHER;
    cls_item.pkind = K_ERR;
    cls_item.opi   = 2'd0;
    if ((source_byte >= "a" && source_byte <= "z") ||
        (source_byte >= "A" && source_byte <= "Z") || source_byte == "_") begin
      cls_item.cls = CC_ALPHA;
    end else if (source_byte >= "0" && source_byte <= "9") begin
      cls_item.cls = CC_DIGIT;
    end else begin
      unique case (source_byte)
        " ", 8'h0d, 8'h09: cls_item.cls = CC_BLANK;
        C_NL:    cls_item.cls = CC_NL;
        "(": begin cls_item.cls = CC_PUNCT; cls_item.pkind = K_LPAREN; end
        ")": begin cls_item.cls = CC_PUNCT; cls_item.pkind = K_RPAREN; end
        "{": begin cls_item.cls = CC_PUNCT; cls_item.pkind = K_LBRACE; end
        "}": begin cls_item.cls = CC_PUNCT; cls_item.pkind = K_RBRACE; end
        ",": begin cls_item.cls = CC_PUNCT; cls_item.pkind = K_COMMA; end
        C_DOT: begin cls_item.cls = CC_PUNCT; cls_item.pkind = K_DOT; end
        "-": begin cls_item.cls = CC_PUNCT; cls_item.pkind = K_MINUS; end
        "+": begin cls_item.cls = CC_PUNCT; cls_item.pkind = K_PLUS; end
        ";": begin cls_item.cls = CC_PUNCT; cls_item.pkind = K_SEMI; end
        "*": begin cls_item.cls = CC_PUNCT; cls_item.pkind = K_STAR; end
        "!": begin cls_item.cls = CC_OPST; cls_item.opi = 2'd0; end
        C_EQ: begin cls_item.cls = CC_OPST; cls_item.opi = 2'd1; end
        "<": begin cls_item.cls = CC_OPST; cls_item.opi = 2'd2; end
        ">": begin cls_item.cls = CC_OPST; cls_item.opi = 2'd3; end
        C_SLASH: cls_item.cls = CC_SLASH;
        C_QUOTE: cls_item.cls = CC_QUOTE;
        default: cls_item.cls = CC_OTHER;
      endcase
    end
  end

  assign src_stall  = count == 2'd2;
  assign push       = src_valid && !src_stall;
  assign item_valid = count != 2'd0;
  assign item       = ent[rp];

  always_ff @(posedge clk) begin
    if (push) ent[wp] <= cls_item;
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (item_take) rp <= !rp;
      count <= count + 2'(push) - 2'(item_take);
    end
  end

endmodule

// ----- hdl/sts_back.sv -----
// back end: scanner state and token formation, up to three tokens per item
module sts_back import sts_pkg::*; #(
  parameter int P = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  item_t      item,
  output logic       item_take,
  input  logic       room,
  output tok_t       toks [3],
  output logic [1:0] tok_cnt
);

  localparam int LW = (P > 20) ? P : 20;
  localparam logic [P-1:0] PosMax = '1;

  logic [P-1:0] pos, tbeg, pos_next, tbeg_next;
  logic [19:0]  line, line_next;
  mode_t        mode, mode_next;
  logic [1:0]   pend, pend_next;
  logic         too_long, too_long_next;
  logic [7:0]   pfx [KwPrefixLen];
  logic         pfx_we;
  logic [2:0]   pfx_idx;

  logic [P-1:0] pos_inc, cur_len, len_inc, dot_pos;
  logic [47:0]  pfx_flat;
  logic [5:0]   word_k;
  logic         alnum, digit;
  tok_t         tk [3];
  logic [1:0]   cnt;
  logic         go_idle;

  function automatic tok_t mk(logic [5:0] k, logic [1:0] e, logic [P-1:0] s,
                              logic [P-1:0] l, logic [19:0] ln);
    tok_t t;
    logic [LW-1:0] se, le;
    se = LW'(s);
    le = LW'(l);
    t.kind  = k;
    t.err   = e;
    t.start = se[19:0];
    t.len   = (le > LW'(20'hfffff)) ? 20'hfffff : le[19:0];
    t.line  = ln;
    t.last  = 1'b0;
    return t;
  endfunction

  assign item_take = item_valid && room;
  assign pos_inc   = (pos == PosMax) ? pos : pos + P'(1);
  assign cur_len   = (pos >= tbeg) ? pos - tbeg : '0;
  assign len_inc   = (pos_inc >= tbeg) ? pos_inc - tbeg : '0;
  assign dot_pos   = (pos > tbeg) ? pos - P'(1) : tbeg;
  assign alnum     = item.cls == CC_ALPHA || item.cls == CC_DIGIT;
  assign digit     = item.cls == CC_DIGIT;

  always_comb begin
    for (int i = 0; i < KwPrefixLen; i++) pfx_flat[47-8*i -: 8] = pfx[i];
    word_k = K_IDENT;
    if (!too_long && cur_len <= P'(KwPrefixLen)) word_k = kw_kind(pfx_flat, cur_len[2:0]);
  end

  // tokens caused by the item at the head of the queue
  always_comb begin
    for (int i = 0; i < 3; i++) tk[i] = '0;
    cnt     = 2'd0;
    go_idle = 1'b0;
    if (item.last) begin
      unique case (mode)
        M_WORD: begin tk[cnt] = mk(word_k, E_NONE, tbeg, cur_len, line); cnt = cnt + 2'd1; end
        M_INT, M_FRAC: begin
          tk[cnt] = mk(K_NUM, E_NONE, tbeg, cur_len, line); cnt = cnt + 2'd1;
        end
        M_NUMDOT: begin
          tk[cnt] = mk(K_NUM, E_NONE, tbeg, dot_pos - tbeg, line); cnt = cnt + 2'd1;
          tk[cnt] = mk(K_DOT, E_NONE, dot_pos, P'(1), line); cnt = cnt + 2'd1;
        end
        M_OP: begin tk[cnt] = mk(OP_KIND[pend], E_NONE, tbeg, P'(1), line); cnt = cnt + 2'd1; end
        M_SLASH: begin tk[cnt] = mk(K_SLASH, E_NONE, tbeg, P'(1), line); cnt = cnt + 2'd1; end
        M_STRING: begin tk[cnt] = mk(K_ERR, E_UNTRM, tbeg, cur_len, line); cnt = cnt + 2'd1; end
        default: ;
      endcase
      tk[cnt] = mk(K_EOF, E_NONE, pos, '0, line); cnt = cnt + 2'd1;
    end else begin
      unique case (mode)
        M_WORD: if (!alnum) begin
          tk[cnt] = mk(word_k, E_NONE, tbeg, cur_len, line); cnt = cnt + 2'd1; go_idle = 1'b1;
        end
        M_INT: if (!digit && item.ch != C_DOT) begin
          tk[cnt] = mk(K_NUM, E_NONE, tbeg, cur_len, line); cnt = cnt + 2'd1; go_idle = 1'b1;
        end
        M_NUMDOT: if (!digit) begin
          tk[cnt] = mk(K_NUM, E_NONE, tbeg, dot_pos - tbeg, line); cnt = cnt + 2'd1;
          tk[cnt] = mk(K_DOT, E_NONE, dot_pos, P'(1), line); cnt = cnt + 2'd1;
          go_idle = 1'b1;
        end
        M_FRAC: if (!digit) begin
          tk[cnt] = mk(K_NUM, E_NONE, tbeg, cur_len, line); cnt = cnt + 2'd1; go_idle = 1'b1;
        end
        M_OP: begin
          if (item.ch == C_EQ) begin
            tk[cnt] = mk(OP_KIND[pend] + 6'd1, E_NONE, tbeg, len_inc, line); cnt = cnt + 2'd1;
          end else begin
            tk[cnt] = mk(OP_KIND[pend], E_NONE, tbeg, P'(1), line); cnt = cnt + 2'd1;
            go_idle = 1'b1;
          end
        end
        M_SLASH: if (item.ch != C_SLASH) begin
          tk[cnt] = mk(K_SLASH, E_NONE, tbeg, P'(1), line); cnt = cnt + 2'd1; go_idle = 1'b1;
        end
        M_COMMENT: go_idle = item.ch == C_NL;
        M_STRING: if (item.ch == C_QUOTE) begin
          tk[cnt] = mk(K_STR, E_NONE, tbeg, len_inc, line); cnt = cnt + 2'd1;
        end
        default: go_idle = 1'b1;
      endcase
      if (go_idle) begin
        if (item.cls == CC_PUNCT) begin
          tk[cnt] = mk(item.pkind, E_NONE, pos, P'(1), line); cnt = cnt + 2'd1;
        end else if (item.cls == CC_OTHER) begin
          tk[cnt] = mk(K_ERR, E_UNEXP, pos, P'(1), line); cnt = cnt + 2'd1;
        end
      end
    end
    if (cnt != 2'd0) tk[cnt - 2'd1].last = 1'b1;
  end

  assign toks    = tk;
  assign tok_cnt = cnt;

  // next scanner state
  always_comb begin
    pos_next      = pos;
    tbeg_next     = tbeg;
    line_next     = line;
    mode_next     = mode;
    pend_next     = pend;
    too_long_next = too_long;
    pfx_we        = 1'b0;
    pfx_idx       = cur_len[2:0];
    if (item.last) begin
      pos_next      = '0;
      tbeg_next     = '0;
      line_next     = 20'd1;
      mode_next     = M_IDLE;
      pend_next     = 2'd0;
      too_long_next = 1'b0;
    end else begin
      unique case (mode)
        M_WORD: if (alnum) begin
          if (cur_len < P'(KwPrefixLen)) pfx_we = 1'b1;
          else too_long_next = 1'b1;
          pos_next = pos_inc;
        end
        M_INT: begin
          if (digit) pos_next = pos_inc;
          else if (item.ch == C_DOT) begin mode_next = M_NUMDOT; pos_next = pos_inc; end
        end
        M_NUMDOT: if (digit) begin mode_next = M_FRAC; pos_next = pos_inc; end
        M_FRAC: if (digit) pos_next = pos_inc;
        M_OP: if (item.ch == C_EQ) begin mode_next = M_IDLE; pos_next = pos_inc; end
        M_SLASH: if (item.ch == C_SLASH) begin mode_next = M_COMMENT; pos_next = pos_inc; end
        M_COMMENT: if (item.ch != C_NL) pos_next = pos_inc;
        M_STRING: begin
          if (item.ch == C_NL && line != 20'hfffff) line_next = line + 20'd1;
          pos_next = pos_inc;
          if (item.ch == C_QUOTE) mode_next = M_IDLE;
        end
        default: ;
      endcase
      if (go_idle) begin
        mode_next = M_IDLE;
        pos_next  = pos_inc;
        unique case (item.cls)
          CC_ALPHA: begin
            tbeg_next = pos; mode_next = M_WORD; too_long_next = 1'b0;
            pfx_we = 1'b1; pfx_idx = 3'd0;
          end
          CC_DIGIT: begin tbeg_next = pos; mode_next = M_INT; end
          CC_NL: if (line != 20'hfffff) line_next = line + 20'd1;
          CC_OPST: begin tbeg_next = pos; mode_next = M_OP; pend_next = item.opi; end
          CC_SLASH: begin tbeg_next = pos; mode_next = M_SLASH; end
          CC_QUOTE: begin tbeg_next = pos; mode_next = M_STRING; end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && pfx_we) pfx[pfx_idx] <= item.ch;
    if (rst) begin
      pos      <= '0;
      tbeg     <= '0;
      line     <= 20'd1;
      mode     <= M_IDLE;
      pend     <= 2'd0;
      too_long <= 1'b0;
    end else if (item_take) begin
      pos      <= pos_next;
      tbeg     <= tbeg_next;
      line     <= line_next;
      mode     <= mode_next;
      pend     <= pend_next;
      too_long <= too_long_next;
    end
  end

endmodule

// ----- hdl/sts_outq.sv -----
// token queue: takes up to three tokens a cycle, hands out one while tok_stall is low
module sts_outq import sts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  tok_t       wtok [3],
  input  logic [1:0] wcnt,
  output logic       room,
  output logic       tok_valid,
  input  logic       tok_stall,
  output tok_t       head
);

  tok_t       mem [8];
  logic [2:0] wp, rp;
  logic [3:0] count;
  logic [1:0] n;
  logic       pop;

  assign n         = wr ? wcnt : 2'd0;
  assign room      = count <= 4'd5;
  assign tok_valid = count != 4'd0;
  assign pop       = tok_valid && !tok_stall;
  assign head      = mem[rp];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < n) mem[wp + 3'(i)] <= wtok[i];
    end
    if (rst) begin
      wp    <= 3'd0;
      rp    <= 3'd0;
      count <= 4'd0;
    end else begin
      wp    <= wp + 3'(n);
      if (pop) rp <= rp + 3'd1;
      count <= count + 4'(n) - 4'(pop);
    end
  end

endmodule

// ----- hdl/script_token_scanner_core.sv -----
// top level of the source token scanner
//
//  channel  valid      stall      payload
//  source   src_valid  src_stall  source_byte, end_of_source
//  token    tok_valid  tok_stall  token_class, error_code, start_offset,
//                                 token_length, line_number, last_of_run
//
// one source byte per cycle sustained while the token queue has room; bytes are
// registered in the two-entry input queue, scanned combinationally, and their tokens
// registered in the token queue. the scanner takes a byte only while the eight-entry
// token queue has three free slots, so a run of multi-token bytes or a held tok_stall slows input.
// rst is synchronous and returns the scanner to offset 0, line 1, queues empty.
module script_token_scanner_core import sts_pkg::*; #(
  parameter int OFFSET_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [7:0]  source_byte,
  input  logic        end_of_source,
  output logic        tok_valid,
  input  logic        tok_stall,
  output logic [5:0]  token_class,
  output logic [1:0]  error_code,
  output logic [19:0] start_offset,
  output logic [19:0] token_length,
  output logic [19:0] line_number,
  output logic        last_of_run
);

  logic       item_valid, item_take, room;
  item_t      item;
  tok_t       toks [3];
  logic [1:0] tok_cnt;
  tok_t       head;

  sts_front u_front (
    .clk, .rst, .src_valid, .src_stall, .source_byte, .end_of_source,
    .item_valid, .item, .item_take
  );

  sts_back #(.P(OFFSET_BITS)) u_back (
    .clk, .rst, .item_valid, .item, .item_take, .room, .toks, .tok_cnt
  );

  sts_outq u_outq (
    .clk, .rst, .wr(item_take), .wtok(toks), .wcnt(tok_cnt), .room,
    .tok_valid, .tok_stall, .head
  );

  assign token_class  = head.kind;
  assign error_code   = head.err;
  assign start_offset = head.start;
  assign token_length = head.len;
  assign line_number  = head.line;
  assign last_of_run  = head.last;

endmodule

// ----- sim/tb_script_token_scanner_core.sv -----
// testbench for the source token scanner: queue-fed driver, predicting monitor
`timescale 1ns / 100ps

module tb_script_token_scanner_core;
  import sts_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } src_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        src_valid = 1'b0;
  logic        src_stall;
  logic [7:0]  source_byte = 8'd0;
  logic        end_of_source = 1'b0;
  logic        tok_valid;
  logic        tok_stall = 1'b0;
  logic [5:0]  token_class;
  logic [1:0]  error_code;
  logic [19:0] start_offset;
  logic [19:0] token_length;
  logic [19:0] line_number;
  logic        last_of_run;

  script_token_scanner_core DUT (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall),
    .source_byte(source_byte), .end_of_source(end_of_source),
    .tok_valid(tok_valid), .tok_stall(tok_stall),
    .token_class(token_class), .error_code(error_code),
    .start_offset(start_offset), .token_length(token_length),
    .line_number(line_number), .last_of_run(last_of_run)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  src_item_t pending_src[$];
  tok_t      expected_tokens[$];
  int        mismatches = 0;
  int        cycle = 0;
  bit        quiet = 1'b0;

  // scanner state mirror
  logic [19:0] pos, tbeg, line;
  mode_t       mode;
  logic [1:0]  popi;
  logic [7:0]  pfx [6];
  bit          too_long;
  int          nres;

  function automatic bit alpha_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] op_base(logic [1:0] i);
    case (i)
      2'd0: return 6'd11;
      2'd1: return 6'd13;
      2'd2: return 6'd17;
      default: return 6'd15;
    endcase
  endfunction

  function automatic logic [19:0] run_len();
    return pos >= tbeg ? pos - tbeg : 20'd0;
  endfunction

  function automatic void push_token(logic [5:0] k, logic [1:0] e, logic [19:0] s,
                                     logic [19:0] n);
    tok_t t;
    if (nres >= 3) return;
    t.kind = k; t.err = e; t.start = s; t.len = n; t.line = line; t.last = 1'b0;
    expected_tokens.push_back(t);
    nres++;
  endfunction

  function automatic void push_word();
    logic [19:0] n;
    logic [5:0]  k;
    string       w;
    n = run_len();
    k = K_IDENT;
    if (!too_long && n <= 6) begin
      w = "";
      for (int i = 0; i < n; i++) w = {w, string'(pfx[i])};
      case (w)
        "and": k = 6'd22;    "class": k = 6'd23; "else": k = 6'd24;
        "false": k = 6'd25;  "for": k = 6'd26;   "fun": k = 6'd27;
        "if": k = 6'd28;     "nil": k = 6'd29;   "or": k = 6'd30;
        "print": k = 6'd31;  "return": k = 6'd32; "super": k = 6'd33;
        "this": k = 6'd34;   "true": k = 6'd35;  "var": k = 6'd36;
        "while": k = 6'd37;  default: k = K_IDENT;
      endcase
    end
    push_token(k, E_NONE, tbeg, n);
  endfunction

  function automatic void push_num_dot();
    logic [19:0] d;
    d = pos > tbeg ? pos - 20'd1 : tbeg;
    push_token(K_NUM, E_NONE, tbeg, d - tbeg);
    push_token(K_DOT, E_NONE, d, 20'd1);
  endfunction

  function automatic void bump_pos();
    if (pos != 20'hfffff) pos++;
  endfunction

  function automatic void bump_line();
    if (line != 20'hfffff) line++;
  endfunction

  function automatic void clear_scanner();
    pos = 20'd0; tbeg = 20'd0; line = 20'd1; mode = M_IDLE; popi = 2'd0; too_long = 1'b0;
  endfunction

  function automatic void begin_token(mode_t m);
    tbeg = pos;
    mode = m;
  endfunction

  function automatic void scan_idle(logic [7:0] c);
    mode = M_IDLE;
    if (alpha_char(c)) begin
      begin_token(M_WORD);
      pfx[0] = c;
      too_long = 1'b0;
    end else if (digit_char(c)) begin
      begin_token(M_INT);
    end else begin
      case (c)
        " ", 8'h0d, 8'h09: ;
        C_NL: bump_line();
        "(": push_token(K_LPAREN, E_NONE, pos, 20'd1);
        ")": push_token(K_RPAREN, E_NONE, pos, 20'd1);
        "{": push_token(K_LBRACE, E_NONE, pos, 20'd1);
        "}": push_token(K_RBRACE, E_NONE, pos, 20'd1);
        ",": push_token(K_COMMA, E_NONE, pos, 20'd1);
        C_DOT: push_token(K_DOT, E_NONE, pos, 20'd1);
        "-": push_token(K_MINUS, E_NONE, pos, 20'd1);
        "+": push_token(K_PLUS, E_NONE, pos, 20'd1);
        ";": push_token(K_SEMI, E_NONE, pos, 20'd1);
        "*": push_token(K_STAR, E_NONE, pos, 20'd1);
        "!": begin begin_token(M_OP); popi = 2'd0; end
        C_EQ: begin begin_token(M_OP); popi = 2'd1; end
        "<": begin begin_token(M_OP); popi = 2'd2; end
        ">": begin begin_token(M_OP); popi = 2'd3; end
        C_SLASH: begin_token(M_SLASH);
        C_QUOTE: begin_token(M_STRING);
        default: push_token(K_ERR, E_UNEXP, pos, 20'd1);
      endcase
    end
    bump_pos();
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    logic [19:0] idx;
    case (mode)
      M_WORD: begin
        if (alpha_char(c) || digit_char(c)) begin
          idx = run_len();
          if (idx < 6) pfx[idx[2:0]] = c;
          else too_long = 1'b1;
          bump_pos();
          return;
        end
        push_word();
      end
      M_INT: begin
        if (digit_char(c)) begin bump_pos(); return; end
        if (c == C_DOT) begin mode = M_NUMDOT; bump_pos(); return; end
        push_token(K_NUM, E_NONE, tbeg, run_len());
      end
      M_NUMDOT: begin
        if (digit_char(c)) begin mode = M_FRAC; bump_pos(); return; end
        push_num_dot();
      end
      M_FRAC: begin
        if (digit_char(c)) begin bump_pos(); return; end
        push_token(K_NUM, E_NONE, tbeg, run_len());
      end
      M_OP: begin
        if (c == C_EQ) begin
          bump_pos();
          push_token(op_base(popi) + 6'd1, E_NONE, tbeg, run_len());
          mode = M_IDLE;
          return;
        end
        push_token(op_base(popi), E_NONE, tbeg, 20'd1);
      end
      M_SLASH: begin
        if (c == C_SLASH) begin mode = M_COMMENT; bump_pos(); return; end
        push_token(K_SLASH, E_NONE, tbeg, 20'd1);
      end
      M_COMMENT: begin
        if (c != C_NL) begin bump_pos(); return; end
      end
      M_STRING: begin
        if (c == C_NL) bump_line();
        bump_pos();
        if (c == C_QUOTE) begin
          push_token(K_STR, E_NONE, tbeg, run_len());
          mode = M_IDLE;
        end
        return;
      end
      default: ;
    endcase
    scan_idle(c);
  endfunction

  function automatic void predict_tokens(src_item_t it);
    int base;
    base = expected_tokens.size();
    nres = 0;
    if (it.fin || it.ch == 8'd0) begin
      case (mode)
        M_WORD: push_word();
        M_INT, M_FRAC: push_token(K_NUM, E_NONE, tbeg, run_len());
        M_NUMDOT: push_num_dot();
        M_OP: push_token(op_base(popi), E_NONE, tbeg, 20'd1);
        M_SLASH: push_token(K_SLASH, E_NONE, tbeg, 20'd1);
        M_STRING: push_token(K_ERR, E_UNTRM, tbeg, run_len());
        default: ;
      endcase
      push_token(K_EOF, E_NONE, pos, 20'd0);
      clear_scanner();
    end else begin
      scan_byte(it.ch);
    end
    if (nres > 0) expected_tokens[base + nres - 1].last = 1'b1;
  endfunction

  function automatic void queue_text(string s);
    src_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.ch = s[i]; it.fin = 1'b0;
      pending_src.push_back(it);
    end
  endfunction

  function automatic void queue_end(logic [7:0] c, bit f);
    src_item_t it;
    it.ch = c; it.fin = f;
    pending_src.push_back(it);
  endfunction

  // driver
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst) begin
      src_valid <= 1'b0;
    end else if (!src_valid || !src_stall) begin
      if (pending_src.size() > 0 && (quiet || $urandom_range(99) >= 13)) begin
        source_byte <= pending_src[0].ch;
        end_of_source <= pending_src[0].fin;
        src_valid <= 1'b1;
        void'(pending_src.pop_front());
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // monitor: predicts on accepted source items, checks accepted tokens
  always @(posedge clk) begin
    tok_t got, want;
    if (rst) begin
      tok_stall <= 1'b0;
    end else begin
      tok_stall <= quiet ? 1'b0 : ($urandom_range(99) < 13);
      if (src_valid && !src_stall) predict_tokens({source_byte, end_of_source});
      if (tok_valid && !tok_stall) begin
        got = {token_class, error_code, start_offset, token_length, line_number,
               last_of_run};
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected token %p", got);
        end else begin
          want = expected_tokens.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) $display("token mismatch exp %p got %p", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  string pieces[] = '{"var ", "x1 ", "while", "returns", "foo_bar ", "12.5", "7.", "3",
                      "!= ", "== ", "<=", ">", "=", "!", "// note\n", "\"str\nx\"",
                      "\n", "(", ")", "{};,-+*", "/ ", "@", "\t", "class ", "and"};

  initial begin
    clear_scanner();
    for (int i = 0; i < 6; i++) pfx[i] = 8'd0;
    // directed: every operator, keywords, numbers, comment, strings, errors
    queue_text("and class else false for fun if nil or print return super this true ");
    queue_end(8'd0, 1'b0);
    queue_text("var while (){},.-+;*/ ! != = == < <= > >= x_9 1.5 7. 8.a ");
    queue_text("// skip me\n\"ab\ncd\" #\r\t");
    queue_end(8'hff, 1'b1);
    queue_text("12.");
    queue_end(8'h00, 1'b1);
    queue_text("\"open");
    queue_end(8'h00, 1'b1);
    queue_text("// open comment");
    queue_end(8'h00, 1'b1);
    queue_text("abcdefgh");
    queue_end(8'h00, 1'b1);
    queue_text("<");
    queue_end(8'h00, 1'b1);
    queue_text("/");
    queue_end(8'h00, 1'b1);
    queue_end(8'h80, 1'b0);
    queue_end(8'h7f, 1'b1);
    // random: mostly well-formed fragments, some raw bytes
    for (int n = 0; n < 110; ) begin
      if ($urandom_range(9) < 8) begin
        queue_text(pieces[$urandom_range(pieces.size() - 1)]);
        n += 3;
      end else begin
        queue_end(8'($urandom_range(255)), 1'b0);
        n++;
      end
      if ($urandom_range(39) == 0) queue_end(8'($urandom_range(255)), 1'b1);
    end
    queue_end(8'h00, 1'b1);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // a long stretch with no idling on either side
    wait (pending_src.size() < 200);
    quiet = 1'b1;
    wait (pending_src.size() < 100);
    quiet = 1'b0;
    wait (pending_src.size() == 0);
    @(negedge clk);
    wait (!src_valid);
    @(negedge clk);
    wait (expected_tokens.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
